[src/qstg_pkg.sv]
// ----------------------------------------------------------------------------
// qstg_pkg - shared types and constants of the queued square tone generator
// Word layouts, operation codes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package qstg_pkg;

    localparam int RATE_W    = 16;
    localparam int HZ_W      = 15;
    localparam int MS_W      = 16;
    localparam int STEP_W    = 17;
    localparam int PROD_W    = 32;
    localparam int PHASE_W   = 19;
    localparam int LEVEL_W   = 8;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    localparam logic [RATE_W-1:0] RATE_RESET = 16'hFFFF;
    // duration product is in units of rate * ms, one sample per thousand
    localparam logic [PROD_W-1:0] MS_PER_SEC  = 32'd1000;
    localparam logic [PROD_W-1:0] TWO_SAMPLES = 32'd2000;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_QUEUE = 1'b1
    } op_t;

    typedef struct packed {
        logic [MS_W-1:0] duration_ms;
        logic [HZ_W-1:0] tone_hz;
        op_t             operation;
    } in_item_t;

    typedef struct packed {
        logic               accepted;
        logic               tone_pending;
        logic               tone_active;
        logic [LEVEL_W-1:0] sample_value;
    } result_t;

endpackage

[src/qstg_in_stage.sv]
// ----------------------------------------------------------------------------
// qstg_in_stage - input register
// Holds one accepted input word until the tone core consumes it.
// ----------------------------------------------------------------------------
module qstg_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  qstg_pkg::in_item_t s_item,
    output logic               item_valid,
    output qstg_pkg::in_item_t item,
    input  logic               item_take
);
    import qstg_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // room when empty or when the held word leaves this cycle
    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (item_take) begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[src/qstg_core.sv]
// ----------------------------------------------------------------------------
// qstg_core - tone state and per-word update
// Queue slot, playing tone, phase error accumulator and output level.
// Sample counts are kept as rate * ms products that drop by 1000 per sample.
// ----------------------------------------------------------------------------
module qstg_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fire,
    input  qstg_pkg::in_item_t            item,
    input  logic [qstg_pkg::RATE_W-1:0]   sample_rate,
    output qstg_pkg::result_t             result
);
    import qstg_pkg::*;

    // state
    logic [STEP_W-1:0]         cstep_reg, cstep_next;
    logic [PROD_W-1:0]         remain_reg, remain_next;
    logic                      active_reg, active_next;
    logic [PHASE_W-1:0]        pe_reg, pe_next;
    logic [STEP_W-1:0]         pstep_reg, pstep_next;
    logic [PROD_W-1:0]         pend_reg, pend_next;
    logic                      pend_valid_reg, pend_valid_next;
    logic [LEVEL_W-1:0]        level_reg, level_next;

    // datapath
    logic [STEP_W-1:0]         lim;
    logic [HZ_W-1:0]           half;
    logic [HZ_W-1:0]           hz_clamp;
    logic [STEP_W-1:0]         q_step;
    logic [PROD_W-1:0]         product;
    logic                      idle;
    logic                      play;
    logic [PROD_W-1:0]         r_eff;
    logic [STEP_W-1:0]         step_eff;
    logic [STEP_W-1:0]         st;
    logic [PHASE_W:0]          sum;
    logic [PHASE_W:0]          sum_wrap;
    logic                      wrap;
    logic                      accepted;

    // queue word arithmetic
    assign half     = sample_rate[RATE_W-1:1];
    assign hz_clamp = (item.tone_hz > half) ? half : item.tone_hz;
    assign q_step   = {hz_clamp, 2'b00};
    assign product  = sample_rate * item.duration_ms;

    // tick arithmetic
    assign lim      = {sample_rate, 1'b0};
    assign idle     = !active_reg;
    assign play     = idle ? pend_valid_reg : 1'b1;
    assign r_eff    = (idle && pend_valid_reg) ? pend_reg : remain_reg;
    assign step_eff = idle ? pstep_reg : cstep_reg;
    assign st       = (step_eff < lim) ? step_eff : lim;
    assign sum      = {pe_reg[PHASE_W-1], pe_reg} + {3'b000, st};
    assign sum_wrap = sum - {3'b000, lim};
    assign wrap     = $signed(sum) >= $signed({4'b0000, sample_rate});

    // next state
    always_comb begin
        cstep_next      = cstep_reg;
        remain_next     = remain_reg;
        active_next     = active_reg;
        pe_next         = pe_reg;
        pstep_next      = pstep_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        level_next      = level_reg;
        accepted        = 1'b0;
        case (item.operation)
            OP_QUEUE: begin
                if (!pend_valid_reg) begin
                    pstep_next      = q_step;
                    pend_next       = product;
                    pend_valid_next = product >= MS_PER_SEC;
                    accepted        = 1'b1;
                end
            end
            OP_TICK: begin
                if (idle) begin
                    cstep_next      = pstep_reg;
                    pend_valid_next = 1'b0;
                end
                if (play) begin
                    remain_next = r_eff - MS_PER_SEC;
                    active_next = r_eff >= TWO_SAMPLES;
                    if (wrap) begin
                        pe_next    = sum_wrap[PHASE_W-1:0];
                        level_next = ~level_reg;
                    end else begin
                        pe_next = sum[PHASE_W-1:0];
                    end
                end
            end
            default: begin
                accepted = 1'b0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cstep_reg      <= '0;
            remain_reg     <= '0;
            active_reg     <= 1'b0;
            pe_reg         <= {3'b000, RATE_RESET};
            pstep_reg      <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            level_reg      <= '0;
        end else if (fire) begin
            cstep_reg      <= cstep_next;
            remain_reg     <= remain_next;
            active_reg     <= active_next;
            pe_reg         <= pe_next;
            pstep_reg      <= pstep_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            level_reg      <= level_next;
        end
    end

    // result word
    assign result = '{accepted:     accepted,
                      tone_pending: pend_valid_next,
                      tone_active:  active_next,
                      sample_value: level_next};

`ifndef SYNTHESIS
    a_level_rail: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg == '0 || level_reg == '1)
        else $error("output level is neither 0 nor 255");

    a_active_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == (remain_reg >= MS_PER_SEC))
        else $error("active flag out of step with remaining count");

    a_idle_tick_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == OP_TICK && !active_reg |=> !pend_valid_reg)
        else $error("idle tick left a tone queued");

    a_queue_no_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == OP_QUEUE |=>
            $stable(remain_reg) && $stable(pe_reg) && $stable(level_reg))
        else $error("queue word moved the waveform");

    a_refused_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && item.operation == OP_QUEUE && pend_valid_reg |=>
            pend_valid_reg && $stable(pend_reg) && $stable(pstep_reg))
        else $error("refused queue word changed the queued tone");
`endif

endmodule

[src/qstg_out_stage.sv]
// ----------------------------------------------------------------------------
// qstg_out_stage - result register
// Holds one result word for the master side and paces the core.
// ----------------------------------------------------------------------------
module qstg_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    output logic              fire,
    input  qstg_pkg::result_t result,
    output logic              m_tvalid,
    input  logic              m_tready,
    output qstg_pkg::result_t m_result
);
    import qstg_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    // core runs when a word waits and the result slot frees up
    assign fire = item_valid && (!valid_reg || m_tready);

    always_comb begin
        valid_next = valid_reg;
        if (fire) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_result = result_reg;

endmodule

[src/queued_square_tone_generator.sv]
// Path: an accepted input word waits in the input register; its core result is
// captured in the result register and shown on m_tdata until it is taken.
// Throughput: one word per cycle while m_tready is high; the core updates its
// state once per word between the input register and the result register.
// Reset: aresetn synchronous, active low; clears queue, tone, level, phase
// error (set to the reset sample rate) and sample_rate (65535).
// ----------------------------------------------------------------------------
// queued_square_tone_generator - square-wave beeper with a one-deep tone queue
// Tick words advance a playing or queued tone one sample; queue words store the next tone.
// ----------------------------------------------------------------------------
module queued_square_tone_generator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [qstg_pkg::RATE_W-1:0]        cfg_wr_data,   // sample_rate
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [qstg_pkg::S_TDATA_W-1:0]     s_tdata,       // tone_hz, duration_ms
    input  logic                               s_tuser,       // operation
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // sample_value, tone_active, tone_pending, accepted
    output logic [qstg_pkg::M_TDATA_W-1:0]     m_tdata
);
    import qstg_pkg::*;

    logic [RATE_W-1:0] rate_reg;
    in_item_t          s_item;
    in_item_t          item;
    logic              item_valid;
    logic              fire;
    result_t           result;
    result_t           m_result;

    // sample rate register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= RATE_RESET;
        end else if (cfg_wr_en) begin
            rate_reg <= cfg_wr_data;
        end
    end

    // unpack input word
    assign s_item = '{duration_ms: s_tdata[HZ_W+MS_W-1:HZ_W],
                      tone_hz:     s_tdata[HZ_W-1:0],
                      operation:   op_t'(s_tuser)};

    qstg_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (fire)
    );

    qstg_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fire        (fire),
        .item        (item),
        .sample_rate (rate_reg),
        .result      (result)
    );

    qstg_out_stage u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .fire       (fire),
        .result     (result),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_result   (m_result)
    );

    // pack result word
    assign m_tdata = {{(M_TDATA_W - $bits(result_t)){1'b0}}, m_result};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb - self-checking bench for the queued square tone generator
// Streams tick and tone-request words with random gaps and back-pressure,
// predicts every result word from a cycle-free model of the tone state and
// checks each result field in order, across a series of sample rates.
// ----------------------------------------------------------------------------
module tb;
    import qstg_pkg::*;

    localparam int SAMPLES_W      = 23;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int MAX_REPORTS    = 50;

    // ------------------------------------------------------------------------
    // tone state predictor and ordered store of expected result words
    // ------------------------------------------------------------------------
    class tone_scoreboard;
        logic [RATE_W-1:0]         rate;
        logic [STEP_W-1:0]         cur_step;
        logic [STEP_W-1:0]         pend_step;
        logic [SAMPLES_W-1:0]      remaining;
        logic [SAMPLES_W-1:0]      pend_samples;
        logic signed [PHASE_W-1:0] phase_err;
        logic [LEVEL_W-1:0]        level;
        result_t                   expected_samples[$];
        int                        errors;
        int                        reports;
        int                        words_in;
        int                        tone_requests;
        int                        tones_stored;
        int                        level_flips;
        int                        results_checked;

        function new();
            rate         = RATE_RESET;
            cur_step     = '0;
            pend_step    = '0;
            remaining    = '0;
            pend_samples = '0;
            phase_err    = {3'b000, RATE_RESET};
            level        = '0;
        endfunction

        function void set_rate(logic [RATE_W-1:0] value);
            rate = value;
        endfunction

        function bit busy();
            return (remaining != 0) || (pend_samples != 0);
        endfunction

        function bit queue_full();
            return pend_samples != 0;
        endfunction

        function int outstanding();
            return expected_samples.size();
        endfunction

        // advance the tone state by one accepted word, queue the result
        function void note_word(op_t op, logic [HZ_W-1:0] hz, logic [MS_W-1:0] ms);
            result_t            r;
            logic [HZ_W-1:0]    hz_c;
            logic [STEP_W-1:0]  lim;
            logic [STEP_W-1:0]  st;
            logic [PROD_W-1:0]  prod;
            int                 ph;
            r = '0;
            words_in++;
            if (op == OP_QUEUE) begin
                tone_requests++;
                // one-deep queue: refused while a tone still waits
                if (pend_samples == 0) begin
                    hz_c = hz;
                    if (hz > (rate >> 1)) begin
                        hz_c = HZ_W'(rate >> 1);
                    end
                    pend_step    = {hz_c, 2'b00};
                    prod         = PROD_W'(rate) * PROD_W'(ms);
                    pend_samples = SAMPLES_W'(prod / MS_PER_SEC);
                    r.accepted   = 1'b1;
                    tones_stored++;
                end
            end else begin
                lim = {rate, 1'b0};
                // idle tick picks up the pending step even with an empty queue
                if (remaining == 0) begin
                    if (pend_samples != 0) begin
                        remaining = pend_samples;
                    end
                    cur_step     = pend_step;
                    pend_samples = '0;
                end
                if (remaining != 0) begin
                    st = (cur_step < lim) ? cur_step : lim;
                    remaining--;
                    ph = int'(phase_err) + int'(st);
                    if (ph >= int'(rate)) begin
                        ph -= int'(lim);
                        level = ~level;
                        level_flips++;
                    end
                    phase_err = ph[PHASE_W-1:0];
                end
            end
            r.sample_value = level;
            r.tone_active  = (remaining != 0);
            r.tone_pending = (pend_samples != 0);
            expected_samples.push_back(r);
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    $display("%0t: %s mismatch in result %0d: expected %0d, actual %0d",
                             $time, name, results_checked, want, got);
                end
                reports++;
            end
        endfunction

        // compare one result word with the oldest expectation
        function void check_word(logic [M_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            got = word[$bits(result_t)-1:0];
            if (expected_samples.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word: expected none, actual 0x%04h",
                         $time, word);
                return;
            end
            want = expected_samples.pop_front();
            results_checked++;
            compare_field("sample_value", want.sample_value, got.sample_value);
            compare_field("tone_active", want.tone_active, got.tone_active);
            compare_field("tone_pending", want.tone_pending, got.tone_pending);
            compare_field("accepted", want.accepted, got.accepted);
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [RATE_W-1:0]      cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;     // tone_hz, duration_ms
    logic                   s_tuser;     // operation
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;     // sample_value, tone_active, tone_pending, accepted

    tone_scoreboard sb;
    int             cur_rate;
    int             rates_written;
    int             stall_count;
    bit             steady;
    bit             hold_req;

    queued_square_tone_generator i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result checking and progress watchdog
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata);
        end
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count + 1 >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // receiver: random ready bursts, one long hold-off on request
    initial begin : receiver
        int  run_left;
        bit  stall;
        m_tready = 1'b0;
        run_left = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
                run_left = 0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    stall    = ($urandom_range(0, 2) == 0);
                    run_left = stall ? $urandom_range(1, 15) : $urandom_range(1, 40);
                    m_tready <= !stall;
                end
                run_left--;
            end
        end
    end

    // offer one word, possibly after a gap, and note it once accepted
    task automatic send_word(op_t op, logic [HZ_W-1:0] hz, logic [MS_W-1:0] ms);
        @(negedge aclk);
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, ms, hz};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_word(op, hz, ms);
    endtask

    task automatic send_tick();
        send_word(OP_TICK, HZ_W'($urandom), MS_W'($urandom));
    endtask

    // rate change only once every result is back and the pipe is quiet
    task automatic write_rate(logic [RATE_W-1:0] rate);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_wr_data <= rate;
        cfg_wr_en   <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_rate(rate);
        cur_rate = rate;
        rates_written++;
    endtask

    // mostly ticks with short tones queued in between; long lengths only
    // where they are refused or the rate keeps them short
    task automatic play_random(int n_words);
        logic [HZ_W-1:0] hz;
        logic [MS_W-1:0] ms;
        int              ms_cap;
        for (int k = 0; k < n_words; k++) begin
            if ($urandom_range(0, 99) < 12) begin
                ms_cap = (cur_rate == 0) ? 65535 : 40000 / cur_rate;
                if (ms_cap < 1) begin
                    ms_cap = 1;
                end
                if (ms_cap > 65535) begin
                    ms_cap = 65535;
                end
                if ($urandom_range(0, 1)) begin
                    hz = HZ_W'($urandom);
                end else begin
                    hz = HZ_W'($urandom_range(0, cur_rate / 2));
                end
                if (sb.queue_full() || cur_rate <= 2) begin
                    ms = MS_W'($urandom);
                end else begin
                    ms = MS_W'($urandom_range(0, ms_cap));
                end
                send_word(OP_QUEUE, hz, ms);
            end else begin
                send_tick();
            end
        end
    endtask

    // main sequence
    initial begin
        sb            = new();
        cur_rate      = RATE_RESET;
        rates_written = 0;
        stall_count   = 0;
        steady        = 1'b0;
        hold_req      = 1'b0;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_TICK;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // reset rate: idle tick, zero-length tone, full queue, queue while playing
        send_word(OP_TICK, '1, '1);
        send_word(OP_QUEUE, 15'd32767, 16'd0);
        send_tick();
        send_word(OP_QUEUE, 15'd30000, 16'd2);
        send_word(OP_QUEUE, 15'd32767, 16'd65535);
        send_tick();
        send_word(OP_QUEUE, 15'd0, 16'd1);
        send_word(OP_QUEUE, 15'd1, 16'd1);
        repeat (4) send_tick();

        // rate drops under a playing tone, step gets limited
        write_rate(16'd8000);
        repeat (3) send_tick();
        hold_req = 1'b1;
        play_random(350);
        while (sb.busy()) send_tick();
        send_word(OP_QUEUE, 15'd3000, 16'd5);
        repeat (3) send_tick();

        // zero rate under a playing tone, then a request clamped to nothing
        write_rate(16'd0);
        repeat (5) send_tick();
        send_word(OP_QUEUE, 15'd12345, 16'd777);
        send_tick();

        write_rate(16'd1);
        play_random(250);
        write_rate(16'd2);
        play_random(100);
        write_rate(16'd44100);
        play_random(300);
        write_rate(16'hFFFF);
        play_random(250);
        steady = 1'b1;
        play_random(150);

        // drain
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("covered %0d words: %0d tone requests, %0d stored, %0d level flips",
                 sb.words_in, sb.tone_requests, sb.tones_stored, sb.level_flips);
        $display("%0d results checked over %0d rate settings, %0d field errors",
                 sb.results_checked, rates_written + 1, sb.errors);
        if (sb.errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[sim.f]
src/qstg_pkg.sv
src/qstg_in_stage.sv
src/qstg_core.sv
src/qstg_out_stage.sv
src/queued_square_tone_generator.sv
tb/tb.sv
